[design/stop_bit_field_decoder_macros.svh]
// Shared assertion macros for the stop-bit decoder
`ifndef STOP_BIT_FIELD_DECODER_MACROS_SVH
`define STOP_BIT_FIELD_DECODER_MACROS_SVH

// Condition that must hold on every enabled clock edge
`define SBFD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies the consequent in the same cycle
`define SBFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies the consequent in the following cycle
`define SBFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/sbfd_pkg.sv]
package sbfd_pkg;

	typedef enum logic [2:0] {
		TY_U32  = 3'd0,
		TY_I32  = 3'd1,
		TY_U64  = 3'd2,
		TY_I64  = 3'd3,
		TY_DEC  = 3'd4,
		TY_MANT = 3'd5,
		TY_STR  = 3'd6,
		TY_SKIP = 3'd7
	} sbfd_type_t;

	typedef enum logic [1:0] {
		KIND_INT = 2'd0,
		KIND_DEC = 2'd1,
		KIND_STR = 2'd2
	} sbfd_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_EXP  = 2'd1,
		ERR_OVF  = 2'd2
	} sbfd_err_t;

	localparam logic [4:0] COUNT_MAX = 5'd20;

	// One classified stream byte as it sits in the queue
	typedef struct packed {
		logic       stop;
		logic [6:0] payload;
		sbfd_type_t req;
	} sbfd_item_t;

	typedef struct packed {
		logic [63:0] value_bits;
		logic [6:0]  exponent;
		sbfd_kind_t  result_kind;
		logic [4:0]  bytes_used;
		sbfd_err_t   error_code;
		logic        last_of_field;
	} sbfd_result_t;

endpackage

[design/stop_bit_field_decoder.sv]
// Channel  | Dir | tdata (low bit up)                                        | tuser       | tlast
// s_       | in  | data_byte[7:0]                                            | req_type    | -
// m_       | out | value_bits[63:0] exponent[70:64] bytes_used[75:71]        | result_kind | last_of_field
//          |     | error_code[77:76] zero[79:78]                             |             |
// One byte is taken per cycle while s_tready is high; a byte that ends a result passes the queue and then the
// output register before m_tvalid rises. Each byte passes a QUEUE_DEPTH-entry queue and one decode step that
// updates the accumulator. s_tready drops only when the queue is full, so the queue absorbs a stalled m_ side.
// The output register frees as it is taken, so m_tready held high keeps one byte per cycle.
// arst_n clears the queue, the field state and the output valid; no clearing pass is needed.
module stop_bit_field_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [2:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // value_bits, exponent, bytes_used, error_code, zero pad
	output logic [1:0]  m_tuser,   // result_kind
	output logic        m_tlast    // last_of_field
);
	import sbfd_pkg::*;

	logic         q_valid;
	logic         q_pop;
	sbfd_item_t   q_item;
	sbfd_result_t res;

	sbfd_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_byte (s_tdata),
		.in_req  (s_tuser),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_item  (q_item)
	);

	sbfd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {2'b00, res.error_code, res.bytes_used, res.exponent, res.value_bits};
	assign m_tuser = res.result_kind;
	assign m_tlast = res.last_of_field;

endmodule

[design/sbfd_front.sv]
module sbfd_front #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic [2:0]        in_req,
	output logic              q_valid,
	input  logic              q_pop,
	output sbfd_pkg::sbfd_item_t q_item
);
	import sbfd_pkg::*;
	`include "stop_bit_field_decoder_macros.svh"

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	sbfd_item_t       store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	sbfd_item_t       item;
	logic             push;
	logic             pop;

	// Split the byte into stop mark and payload, and tag the request type
	always_comb begin
		item.stop    = in_byte[7];
		item.payload = in_byte[6:0];
		item.req     = sbfd_type_t'(in_req);
	end

	assign in_ready = (count_q != CNT_FULL);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SBFD_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_FULL, "queue count past depth")
	`SBFD_ASSERT_IMPL(a_ptr_match, clk, arst_n, count_q == '0, wr_ptr_q == rd_ptr_q, "empty queue with split pointers")
	`SBFD_ASSERT_NEXT(a_fill, clk, arst_n, push && !pop, count_q != '0, "push lost")

endmodule

[design/sbfd_back.sv]
module sbfd_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_pop,
	input  sbfd_pkg::sbfd_item_t   q_item,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sbfd_pkg::sbfd_result_t out_res
);
	import sbfd_pkg::*;
	`include "stop_bit_field_decoder_macros.svh"

	logic [63:0]  acc_q;
	logic [4:0]   cnt_q;
	logic         open_q;
	sbfd_type_t   type_q;
	logic         mant_q;
	logic [6:0]   exp_q;
	logic         start_q;
	logic         ovf_q;
	logic         valid_s1;
	sbfd_result_t res_s1;

	logic [63:0]  acc_n;
	logic [4:0]   cnt_n;
	logic         open_n;
	sbfd_type_t   type_n;
	logic         mant_n;
	logic [6:0]   exp_n;
	logic         start_n;
	logic         ovf_n;
	logic         emit;
	sbfd_result_t res_n;

	assign q_pop     = q_valid && (!valid_s1 || out_ready);
	assign out_valid = valid_s1;
	assign out_res   = res_s1;

	always_comb begin
		logic        w32;
		logic        sgn;
		logic        mant_c;
		logic        start_c;
		logic        ovf_c;
		logic [63:0] acc_c;
		logic [63:0] shifted;
		logic        in_range;

		acc_n   = acc_q;
		cnt_n   = cnt_q;
		open_n  = open_q;
		type_n  = type_q;
		mant_n  = mant_q;
		exp_n   = exp_q;
		start_n = start_q;
		ovf_n   = ovf_q;
		emit    = 1'b0;
		res_n   = '0;
		w32     = 1'b0;
		sgn     = 1'b0;
		shifted = '0;
		in_range = 1'b0;
		mant_c  = mant_q;
		start_c = start_q;
		ovf_c   = ovf_q;
		acc_c   = acc_q;

		if (q_pop && (open_q || q_item.req != TY_SKIP)) begin
			// Open a new field on its first byte
			if (!open_q) begin
				type_n  = q_item.req;
				cnt_n   = '0;
				exp_n   = '0;
				mant_c  = 1'b0;
				start_c = 1'b1;
				ovf_c   = 1'b0;
				acc_c   = '0;
			end
			open_n  = 1'b1;
			mant_n  = mant_c;
			start_n = start_c;
			ovf_n   = ovf_c;
			acc_n   = acc_c;
			if (cnt_n < COUNT_MAX) begin
				cnt_n = cnt_n + 1'b1;
			end

			if (type_n == TY_STR) begin
				emit                = 1'b1;
				res_n.value_bits    = {57'd0, q_item.payload};
				res_n.result_kind   = KIND_STR;
				res_n.bytes_used    = cnt_n;
				res_n.error_code    = ERR_NONE;
				res_n.last_of_field = q_item.stop;
				if (q_item.stop) begin
					open_n  = 1'b0;
					mant_n  = 1'b0;
					start_n = 1'b0;
					ovf_n   = 1'b0;
					acc_n   = '0;
				end
			end else begin
				w32 = (type_n == TY_U32) || (type_n == TY_I32) ||
					(type_n == TY_DEC && !mant_c);
				sgn = (type_n != TY_U32) && (type_n != TY_U64);

				if (start_c) begin
					acc_n   = {{57{sgn && q_item.payload[6]}}, q_item.payload};
					start_n = 1'b0;
				end else begin
					// Flag bits that would be pushed out of the type's width
					if (sgn) begin
						if (w32) begin
							if (acc_c[63:24] != '0 && acc_c[63:24] != '1) ovf_n = 1'b1;
						end else begin
							if (acc_c[63:56] != '0 && acc_c[63:56] != '1) ovf_n = 1'b1;
						end
					end else begin
						if (w32) begin
							if (acc_c[63:25] != '0) ovf_n = 1'b1;
						end else begin
							if (acc_c[63:57] != '0) ovf_n = 1'b1;
						end
					end
					shifted = {acc_c[56:0], q_item.payload};
					if (w32) begin
						acc_n = {{32{sgn && shifted[31]}}, shifted[31:0]};
					end else begin
						acc_n = shifted;
					end
				end

				if (q_item.stop) begin
					in_range = !ovf_n && ((acc_n[63:6] == '0) ||
						(acc_n[63:6] == '1 && acc_n[5:0] != '0));
					if (type_n == TY_DEC && !mant_c) begin
						if (!in_range) begin
							emit                = 1'b1;
							res_n.result_kind   = KIND_DEC;
							res_n.bytes_used    = cnt_n;
							res_n.error_code    = ERR_EXP;
							res_n.last_of_field = 1'b1;
							open_n  = 1'b0;
							mant_n  = 1'b0;
							start_n = 1'b0;
							ovf_n   = 1'b0;
							acc_n   = '0;
						end else begin
							// Hold the exponent and start the mantissa
							exp_n   = acc_n[6:0];
							mant_n  = 1'b1;
							start_n = 1'b1;
							ovf_n   = 1'b0;
							acc_n   = '0;
						end
					end else begin
						emit                = 1'b1;
						res_n.value_bits    = acc_n;
						res_n.exponent      = (type_n == TY_DEC) ? exp_n : 7'd0;
						res_n.result_kind   = (type_n == TY_DEC || type_n == TY_MANT) ?
							KIND_DEC : KIND_INT;
						res_n.bytes_used    = cnt_n;
						res_n.error_code    = ovf_n ? ERR_OVF : ERR_NONE;
						res_n.last_of_field = 1'b1;
						open_n  = 1'b0;
						mant_n  = 1'b0;
						start_n = 1'b0;
						ovf_n   = 1'b0;
						acc_n   = '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			cnt_q    <= '0;
			open_q   <= 1'b0;
			type_q   <= TY_U32;
			mant_q   <= 1'b0;
			exp_q    <= '0;
			start_q  <= 1'b0;
			ovf_q    <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			acc_q   <= acc_n;
			cnt_q   <= cnt_n;
			open_q  <= open_n;
			type_q  <= type_n;
			mant_q  <= mant_n;
			exp_q   <= exp_n;
			start_q <= start_n;
			ovf_q   <= ovf_n;
			if (q_pop) begin
				valid_s1 <= emit;
			end else if (out_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && emit) begin
			res_s1 <= res_n;
		end
	end

	`SBFD_ASSERT_IMPL(a_closed_clean, clk, arst_n, !open_q, !mant_q && !ovf_q && acc_q == '0, "closed field holds state")
	`SBFD_ASSERT_IMPL(a_mid_string, clk, arst_n, valid_s1 && !res_s1.last_of_field, res_s1.result_kind == KIND_STR, "open result outside string")
	`SBFD_ASSERT_IMPL(a_exp_kind, clk, arst_n, valid_s1 && res_s1.exponent != '0, res_s1.result_kind == KIND_DEC, "exponent on non-decimal")
	`SBFD_ASSERT_IMPL(a_count_cap, clk, arst_n, valid_s1, res_s1.bytes_used != '0 && res_s1.bytes_used <= COUNT_MAX, "byte count out of range")

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import sbfd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // data_byte
	logic [2:0]  s_tuser = 3'd0;   // req_type
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;          // value_bits, exponent, bytes_used, error_code, zero pad
	logic [1:0]  m_tuser;          // result_kind
	logic        m_tlast;          // last_of_field

	stop_bit_field_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sbfd_item_t   pending_bytes[$];
	sbfd_result_t pending_results[$];
	sbfd_item_t   next_byte;
	sbfd_result_t want;
	int           fed_items = 0;
	int           failures = 0;
	int           cycles = 0;
	int           phase = 0;
	int           tx_idle_pct[3] = '{20, 53, 0};
	int           rx_idle_pct[3] = '{53, 20, 0};
	int           hold_left = 0;
	bit           hold_done = 1'b0;

	// Decoder state as the block should hold it
	logic [63:0] acc = '0;
	logic [4:0]  byte_count = '0;
	logic        field_open = 1'b0;
	sbfd_type_t  field_type = TY_U32;
	logic        in_mantissa = 1'b0;
	logic [6:0]  held_exp = '0;
	logic        neg_start = 1'b0;
	logic        at_start = 1'b0;
	logic        overflow = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] trim_to_width(logic [63:0] v, int w, bit sgn);
		if (w == 32) begin
			v[63:32] = (sgn && v[31]) ? 32'hffff_ffff : 32'h0;
		end
		return v;
	endfunction

	function automatic void expect_result(logic [63:0] value, logic [6:0] expo, sbfd_kind_t kind,
			sbfd_err_t err, logic last);
		sbfd_result_t r;
		r.value_bits = value;
		r.exponent = expo;
		r.result_kind = kind;
		r.bytes_used = byte_count;
		r.error_code = err;
		r.last_of_field = last;
		pending_results.push_back(r);
	endfunction

	function automatic void close_field();
		field_open = 1'b0;
		in_mantissa = 1'b0;
		at_start = 1'b0;
		overflow = 1'b0;
		acc = '0;
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic [2:0] rt);
		logic        stop;
		logic [63:0] p;
		logic [63:0] hi;
		int          w;
		bit          sgn;
		bit          exp_ok;
		stop = b[7];
		p = {57'd0, b[6:0]};
		if (!field_open) begin
			// a skip selector on a field's first byte is dropped whole
			if (rt == TY_SKIP)
				return;
			field_type = sbfd_type_t'(rt);
			field_open = 1'b1;
			byte_count = '0;
			in_mantissa = 1'b0;
			held_exp = '0;
			at_start = 1'b1;
			overflow = 1'b0;
			acc = '0;
		end
		if (byte_count < COUNT_MAX)
			byte_count++;

		if (field_type == TY_STR) begin
			expect_result(p, 7'd0, KIND_STR, ERR_NONE, stop);
			if (stop)
				close_field();
			return;
		end

		case (field_type)
			TY_U32:  begin w = 32; sgn = 1'b0; end
			TY_I32:  begin w = 32; sgn = 1'b1; end
			TY_U64:  begin w = 64; sgn = 1'b0; end
			TY_DEC:  begin w = in_mantissa ? 64 : 32; sgn = 1'b1; end
			default: begin w = 64; sgn = 1'b1; end
		endcase

		if (at_start) begin
			neg_start = sgn && b[6];
			acc = neg_start ? (p | ~64'd127) : p;
			acc = trim_to_width(acc, w, sgn);
			at_start = 1'b0;
		end else begin
			// flag bits that would be pushed out of the type's width
			if (sgn) begin
				hi = acc >> (w - 8);
				if (hi != 0 && hi != ({64{1'b1}} >> (w - 8)))
					overflow = 1'b1;
			end else if ((acc >> (w - 7)) != 0) begin
				overflow = 1'b1;
			end
			acc = trim_to_width((acc << 7) | p, w, sgn);
		end

		if (!stop)
			return;

		if (field_type == TY_DEC && !in_mantissa) begin
			exp_ok = !overflow && (acc <= 64'd63 || acc >= (64'd0 - 64'd63));
			if (!exp_ok) begin
				expect_result(64'd0, 7'd0, KIND_DEC, ERR_EXP, 1'b1);
				close_field();
				return;
			end
			held_exp = acc[6:0];
			in_mantissa = 1'b1;
			at_start = 1'b1;
			overflow = 1'b0;
			acc = '0;
			return;
		end

		expect_result(acc, (field_type == TY_DEC) ? held_exp : 7'd0,
			(field_type >= TY_DEC) ? KIND_DEC : KIND_INT,
			overflow ? ERR_OVF : ERR_NONE, 1'b1);
		close_field();
	endfunction

	task automatic push_byte(logic [7:0] data, logic [2:0] req);
		pending_bytes.push_back('{data[7], data[6:0], sbfd_type_t'(req)});
		fed_items++;
	endtask

	// Encode v as stop-bit groups, shortest form plus pad leading fill groups
	task automatic push_value(logic [63:0] v, bit sgn, int pad, logic [2:0] first_req);
		logic signed [63:0] sv;
		logic [63:0]        top;
		logic [6:0]         grp;
		int                 n;
		int                 total;
		sv = v;
		n = 1;
		while (1) begin
			// keep the arithmetic shift apart from the unsigned one
			if (sgn)
				top = sv >>> (7 * n - 1);
			else
				top = v >> (7 * n);
			if (n == 10 || top == 0 || (sgn && top == {64{1'b1}}))
				break;
			n++;
		end
		total = n + pad;
		for (int i = 0; i < total; i++) begin
			if (i < pad)
				grp = (sgn && v[63]) ? 7'h7f : 7'h00;
			else if (sgn)
				grp = 7'(sv >>> (7 * (total - 1 - i)));
			else
				grp = 7'(v >> (7 * (total - 1 - i)));
			push_byte({i == total - 1, grp}, (i == 0) ? first_req : 3'($urandom_range(0, 7)));
		end
	endtask

	task automatic gen_field();
		logic [2:0]  rt;
		logic [63:0] v;
		longint      le;
		int          e;
		int          n;
		int          pad;
		bit          sgn;
		rt = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 11) == 0)
			pad = $urandom_range(4, 18);
		else
			pad = ($urandom_range(0, 3) == 0) ? 1 : 0;

		if (rt == TY_SKIP) begin
			pending_bytes.push_back('{1'($urandom), 7'($urandom), TY_SKIP});
			return;
		end

		// raw bytes: arbitrary content, often long enough to overflow
		if ($urandom_range(0, 9) == 0) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				push_byte({i == n - 1, 7'($urandom)}, (i == 0) ? rt : 3'($urandom_range(0, 7)));
			return;
		end

		case (rt)
			TY_STR: begin
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					push_byte({i == n - 1, 7'($urandom)}, (i == 0) ? rt : 3'($urandom_range(0, 7)));
			end
			TY_DEC: begin
				n = $urandom_range(0, 9);
				if (n < 7) begin
					e = $urandom_range(0, 126);
					e = e - 63;
				end else if (n < 9) begin
					e = $urandom_range(64, 300);
					if ($urandom_range(0, 1))
						e = -e;
				end else begin
					e = $urandom;
				end
				le = e;
				push_value(64'(le), 1'b1, pad, rt);
				// no mantissa follows an exponent that is out of range
				if (e >= -63 && e <= 63) begin
					v = {$urandom, $urandom} >> $urandom_range(0, 63);
					if ($urandom_range(0, 1))
						v = -v;
					push_value(v, 1'b1, $urandom_range(0, 1), 3'($urandom_range(0, 7)));
				end
			end
			default: begin
				sgn = (rt == TY_I32 || rt == TY_I64 || rt == TY_MANT);
				v = {$urandom, $urandom} >> $urandom_range(0, 63);
				if (sgn && $urandom_range(0, 1))
					v = -v;
				if ($urandom_range(0, 7) != 0) begin
					if (rt == TY_U32)
						v = {32'd0, v[31:0]};
					else if (rt == TY_I32)
						v = {{32{v[31]}}, v[31:0]};
				end
				push_value(v, sgn, pad, rt);
			end
		endcase
	endtask

	// Offer requests from the queue, idling at the phase's rate
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct[phase]) begin
				next_byte = pending_bytes.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {next_byte.stop, next_byte.payload};
				s_tuser <= next_byte.req;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (phase == 2 && !hold_done) begin
			// hold off long enough for the input side to back up
			m_tready <= 1'b0;
			hold_left <= 300;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct[phase]);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result: value_bits %h", m_tdata[63:0]);
					failures++;
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[63:0] !== want.value_bits) begin
						$error("value_bits: expected %h, got %h", want.value_bits, m_tdata[63:0]);
						failures++;
					end
					if (m_tdata[70:64] !== want.exponent) begin
						$error("exponent: expected %0d, got %0d",
							$signed(want.exponent), $signed(m_tdata[70:64]));
						failures++;
					end
					if (m_tuser !== want.result_kind) begin
						$error("result_kind: expected %0d, got %0d", want.result_kind, m_tuser);
						failures++;
					end
					if (m_tdata[75:71] !== want.bytes_used) begin
						$error("bytes_used: expected %0d, got %0d", want.bytes_used, m_tdata[75:71]);
						failures++;
					end
					if (m_tdata[77:76] !== want.error_code) begin
						$error("error_code: expected %0d, got %0d", want.error_code, m_tdata[77:76]);
						failures++;
					end
					if (m_tlast !== want.last_of_field) begin
						$error("last_of_field: expected %0d, got %0d", want.last_of_field, m_tlast);
						failures++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// single-byte values of each integer type
		push_byte(8'h80, TY_U32);
		push_byte(8'hC0, TY_I32);
		push_byte(8'hFF, TY_U64);
		push_byte(8'hFF, TY_I64);
		// string; the second byte's selector is ignored inside the field
		push_byte(8'h41, TY_STR);
		push_byte(8'hC2, TY_U32);
		// exponent at both range limits, then one just past it
		push_byte(8'hBF, TY_DEC);
		push_byte(8'hFF, TY_U32);
		push_byte(8'hC1, TY_DEC);
		push_byte(8'h80, TY_STR);
		push_byte(8'h00, TY_DEC);
		push_byte(8'hC0, TY_DEC);
		push_byte(8'h85, TY_MANT);
		// skip selector at a field start
		pending_bytes.push_back('{1'b1, 7'h55, TY_SKIP});
		// widest unsigned 32-bit value, then one past it
		push_value(64'hFFFF_FFFF, 1'b0, 0, TY_U32);
		push_value(64'h1_0000_0000, 1'b0, 0, TY_U32);

		for (int ph = 0; ph < 3; ph++) begin
			phase = ph;
			while (fed_items < 440 * (ph + 1))
				gen_field();
			while (pending_bytes.size() != 0)
				@(posedge clk);
			@(negedge clk);
		end

		while (s_tvalid || pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
